/* hw/rtl/prb_pkg.sv */
// package for the polynomial root bounds block: widths, codes and shared types
`default_nettype none
package prb_pkg;
	localparam int unsigned MaxDegreeDefault = 16;
	localparam int unsigned CoefW = 32;
	localparam logic [31:0] OneQ16 = 32'h0001_0000;
	localparam logic [31:0] SatQ16 = 32'h7FFF_FFFF;

	// status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_LEAD_BAD  = 2'd1,
		ST_A0_ZERO   = 2'd2,
		ST_DEGREE    = 2'd3
	} status_t;

	// request to the shared multiplier
	typedef struct packed {
		logic        start;
		logic [47:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod_shr;
	} mul_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/prb_mul.sv */
// shared multiplier: 48 x 32 bit product in two 24 x 32 partial steps, result shifted by 16
`default_nettype none
module prb_mul (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire prb_pkg::mul_req_t req,
	output prb_pkg::mul_rsp_t      rsp
);
	import prb_pkg::*;

	logic [1:0]  phase_q;
	logic [47:0] a_q;
	logic [31:0] b_q;
	logic [79:0] acc_q;
	logic [55:0] part;

	// one partial product of 24 x 32 bits per cycle
	assign part = (phase_q[0] ? {32'd0, a_q[23:0]} : {32'd0, a_q[47:24]}) * {24'd0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (req.start) begin
			phase_q <= 2'd1;
		end else if (phase_q == 2'd1) begin
			phase_q <= 2'd2;
		end else if (phase_q == 2'd2) begin
			phase_q <= 2'd3;
		end else begin
			phase_q <= 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (phase_q == 2'd1) begin
			acc_q <= {24'd0, part};
		end else if (phase_q == 2'd2) begin
			acc_q <= acc_q + {part, 24'd0};
		end
	end

	assign rsp.done = (phase_q == 2'd3);
	assign rsp.prod_shr = acc_q[79:16];
endmodule
`default_nettype wire

/* hw/rtl/prb_div.sv */
// shared restoring divider: floor(2^32 / d), one quotient bit per cycle
`default_nettype none
module prb_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [32:0]      quotient
);
	import prb_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [31:0] den_q;
	logic [33:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], (cnt_q == 6'd32)};
	assign trial = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// dividend is 2^32: a single one bit fed in at the top step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/polynomial_root_bounds_top.sv */
// top level of the polynomial root bounds block: store, sequencer and result register
//
// Usage: coefficients a_n down to a_0 enter on the s_axis channel, one per
// transaction, tdata = coefficient (signed Q16.16), tlast marks a_0.
// A coefficient without tlast is stored as it is accepted, so loading runs at
// one coefficient per cycle while no earlier result waits. On tlast the
// sequencer computes four Lagrange bounds. Each variant first scans its
// coefficients, then, if one of them is negative, runs a 31-bit binary search
// over the root; each candidate takes up to n-k products through the shared
// multiplier. Two reciprocals are then computed in the divider, one after the
// other. An error status skips the bounds and is offered directly.
// One result per tlast leaves on m_axis; tdata packs positive_low,
// positive_high, negative_low, negative_high and status from bit 0 upward.
// s_axis_tready is low while a bound is being computed or a result waits.
// If the receiver stalls, the result stays in its register and no new
// transaction is taken. Reset clears the count, overflow flag and sequencer;
// the coefficient memory is not cleared.
`default_nettype none
module polynomial_root_bounds_top #(
	parameter int unsigned MAX_DEGREE = prb_pkg::MaxDegreeDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,  // coefficient[31:0]
	input  wire logic         s_axis_tlast,  // last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// positive_low[30:0], positive_high[61:31], negative_low[93:62],
	// negative_high[125:94], status[127:126]
	output logic [127:0]      m_axis_tdata
);
	import prb_pkg::*;

	localparam int unsigned Depth = MAX_DEGREE + 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam int unsigned IdxW = $clog2(Depth);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_SCAN   = 11'b00000000010,
		S_SCANW  = 11'b00000000100,
		S_CAND   = 11'b00000001000,
		S_MUL    = 11'b00000010000,
		S_MULW   = 11'b00000100000,
		S_NEXTB  = 11'b00001000000,
		S_DIV2   = 11'b00010000000,
		S_DIV4   = 11'b00100000000,
		S_CHECK  = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [31:0]     mem [Depth];
	logic [31:0]     rd_q;
	logic [IdxW-1:0] rd_addr;
	logic [CntW-1:0] count_q;
	logic            overflow_q;
	logic [IdxW-1:0] n_q;
	logic [31:0]     a0_q;
	logic [31:0]     lead_raw_q;

	logic [1:0]      var_q;
	logic [IdxW:0]   idx_q;
	logic            found_q;
	logic [IdxW-1:0] k_q;
	logic [32:0]     lowest_q;
	logic            flip_q;
	logic [32:0]     lead_q;
	logic [31:0]     root_q;
	logic [4:0]      bit_q;
	logic [31:0]     cand_q;
	logic [63:0]     p_q;
	logic [IdxW:0]   step_q;
	logic [31:0]     l_q [4];
	logic [31:0]     recip2_q;
	status_t         status_q;
	logic [127:0]    out_q;
	logic            out_valid_q;

	mul_req_t  mreq;
	mul_rsp_t  mrsp;
	logic      dstart;
	logic      ddone;
	logic [32:0] dquo;
	logic [31:0] ddiv;

	prb_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	prb_div u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .divisor(ddiv),
		.done(ddone), .quotient(dquo));

	logic in_acc;
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// variant coefficient index j (of x^j) to store address
	logic [IdxW-1:0] j_idx;
	logic            j_odd;
	assign j_idx = idx_q[IdxW-1:0];
	assign j_odd = j_idx[0];
	assign rd_addr = var_q[0] ? j_idx : IdxW'(n_q - j_idx);

	// sign-adjusted coefficient of the current variant
	logic [32:0] cval;
	logic        neg_v;
	logic        negc;
	assign neg_v = flip_q ^ (var_q[1] & j_odd);
	assign cval = neg_v ? (33'd0 - {rd_q[31], rd_q}) : {rd_q[31], rd_q};
	assign negc = cval[32];

	logic [32:0] mag33;
	assign mag33 = 33'd0 - lowest_q;

	logic [IdxW-1:0] m_w;
	assign m_w = IdxW'(n_q - k_q);

	logic [32:0] lsum;
	assign lsum = {1'b0, OneQ16} + {1'b0, root_q};

	// coefficient store, a_0 included, and registered read port
	always_ff @(posedge clk) begin
		if (in_acc && count_q < CntW'(Depth)) begin
			mem[count_q[IdxW-1:0]] <= s_axis_tdata;
		end
		rd_q <= mem[rd_addr];
	end

	assign mreq.start = (state_q == S_MUL);
	assign mreq.a = p_q[47:0];
	assign mreq.b = cand_q;
	assign dstart = (state_q == S_DIV2 || state_q == S_DIV4) && !idx_q[0];
	assign ddiv = (state_q == S_DIV2) ? l_q[1] : l_q[3];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!s_axis_tlast) begin
							if (count_q < CntW'(Depth)) count_q <= count_q + CntW'(1);
							else overflow_q <= 1'b1;
						end else begin
							count_q <= '0;
							overflow_q <= 1'b0;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (status_q != ST_OK) state_q <= S_OUT;
					else state_q <= S_SCANW;
				end
				S_SCANW: state_q <= S_SCAN;
				S_SCAN: begin
					if (idx_q == '0) state_q <= (!found_q && !negc) ? S_NEXTB : S_CAND;
					else state_q <= S_SCANW;
				end
				S_CAND: state_q <= S_MUL;
				S_MUL: state_q <= S_MULW;
				S_MULW: begin
					if (mrsp.done) begin
						if (step_q == (IdxW+1)'(1) ||
							(cand_q >= OneQ16 && mrsp.prod_shr > {31'd0, mag33}))
							state_q <= S_NEXTB;
						else state_q <= S_MUL;
					end
				end
				S_NEXTB: begin
					if (!found_q || bit_q == 5'd0) begin
						if (var_q == 2'd3) state_q <= S_DIV2;
						else state_q <= S_SCANW;
					end else state_q <= S_CAND;
				end
				S_DIV2: if (ddone) state_q <= S_DIV4;
				S_DIV4: if (ddone) state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && s_axis_tlast) begin
					n_q <= count_q[IdxW-1:0];
					a0_q <= s_axis_tdata;
					lead_raw_q <= (count_q == '0) ? s_axis_tdata : mem[0];
					if (overflow_q || count_q >= CntW'(Depth) || count_q == '0)
						status_q <= ST_DEGREE;
					else if (mem[0][31] || mem[0] == 32'd0) status_q <= ST_LEAD_BAD;
					else if (s_axis_tdata == 32'd0) status_q <= ST_A0_ZERO;
					else status_q <= ST_OK;
				end
			end
			S_CHECK: begin
				var_q <= 2'd0;
				idx_q <= {1'b0, n_q};
				found_q <= 1'b0;
				lowest_q <= '0;
				flip_q <= lead_raw_q[31];
			end
			S_SCAN: begin
				if (negc && !found_q) begin
					found_q <= 1'b1;
					k_q <= j_idx;
				end
				if ($signed(cval) < $signed(lowest_q)) lowest_q <= cval;
				if (idx_q == {1'b0, n_q}) lead_q <= cval;
				if (idx_q != '0) idx_q <= idx_q - (IdxW+1)'(1);
				else begin
					root_q <= '0;
					bit_q <= 5'd30;
				end
			end
			S_CAND: begin
				cand_q <= root_q | (32'd1 << bit_q);
				p_q <= {31'd0, lead_q};
				step_q <= {1'b0, m_w};
			end
			S_MUL: ;
			S_MULW: begin
				if (mrsp.done) begin
					p_q <= mrsp.prod_shr;
					step_q <= step_q - (IdxW+1)'(1);
					if (step_q == (IdxW+1)'(1) && mrsp.prod_shr <= {31'd0, mag33})
						root_q <= cand_q;
				end
			end
			S_NEXTB: begin
				if (!found_q || bit_q == 5'd0) begin
					l_q[var_q] <= !found_q ? OneQ16 :
						(lsum > {1'b0, SatQ16} ? SatQ16 : lsum[31:0]);
					var_q <= var_q + 2'd1;
					// after the last variant idx_q[0] serves as the divider start flag
					idx_q <= (var_q == 2'd3) ? (IdxW+1)'(0) : {1'b0, n_q};
					found_q <= 1'b0;
					lowest_q <= '0;
					// next variant's leading sign
					unique case (var_q)
						2'd0: flip_q <= a0_q[31];
						2'd1: flip_q <= lead_raw_q[31] ^ n_q[0];
						2'd2: flip_q <= a0_q[31] ^ n_q[0];
						default: flip_q <= 1'b0;
					endcase
				end else bit_q <= bit_q - 5'd1;
			end
			S_DIV2: begin
				if (ddone) begin
					recip2_q <= dquo[31:0];
					idx_q[0] <= 1'b0;
				end else begin
					idx_q[0] <= 1'b1;
				end
			end
			S_DIV4: begin
				idx_q[0] <= 1'b1;
				if (ddone) begin
					out_q <= {status_q, 32'(32'd0 - dquo[31:0]), 32'(32'd0 - l_q[2]),
						l_q[0][30:0], recip2_q[30:0]};
				end
			end
			S_OUT: begin
				if (status_q != ST_OK && !out_valid_q) out_q <= {status_q, 126'd0};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !s_axis_tready)
		else $error("accepted with result pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("count beyond depth");
`endif
endmodule
`default_nettype wire
